// File: hw/rtl/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared types and constants for the record table search and sort block.
// ----------------------------------------------------------------------------
package rtss_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    FN_APPEND  = 3'd0,
    FN_DELETE  = 3'd1,
    FN_REPLACE = 3'd2,
    FN_FIND    = 3'd3,
    FN_SORT    = 3'd4,
    FN_DUMP    = 3'd5
  } func_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_ROLE  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SORT_OUTER,
    S_SORT_RD,
    S_SORT_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch_in;     // capture the transaction fields
    logic [2:0] rd_sel;       // read address source
    logic       rd_en;
    logic       wr_new;       // write new record at wr address
    logic [1:0] wr_sel;       // wr_new address: 0 count, 1 hit
    logic       wr_shift;     // write shifted entry (i <- read data)
    logic       swap_a;       // write entry best at i
    logic       swap_b;       // write saved i entry at best
    logic       i_clr;        // i <- 0 (dump/sort) or search start
    logic       i_inc;
    logic       j_init;       // j <- i+1, best <- i, capture best data
    logic       j_inc;
    logic       best_upd;     // best <- j when better
    logic       save_i;       // keep entry i for swap
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [1:0] emit_kind;    // 0 error, 1 new, 2 hit, 3 read data at i
    logic [2:0] emit_status;
    logic       emit_last;
  } cmd_t;

  localparam logic [2:0] RD_I = 3'd0;
  localparam logic [2:0] RD_I1 = 3'd1;
  localparam logic [2:0] RD_J = 3'd2;
  localparam logic [2:0] RD_BEST = 3'd3;

  localparam logic [1:0] WR_COUNT = 2'd0;
  localparam logic [1:0] WR_HIT = 2'd1;

  localparam logic [1:0] EK_ERR = 2'd0;
  localparam logic [1:0] EK_NEW = 2'd1;
  localparam logic [1:0] EK_HIT = 2'd2;
  localparam logic [1:0] EK_RD  = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic       role_ok;
    logic       full;
    logic       empty;
    logic       match;       // read data id equals key
    logic       better;      // read data beats best
    logic       i_end;       // i + 1 >= count
    logic       i_last_out;  // i + 1 == count
    logic       j_end;       // j + 1 >= count
    logic       best_is_i;
  } stat_t;

endpackage

// File: hw/rtl/record_table_search_sort_top.sv
// ----------------------------------------------------------------------------
// record_table_search_sort_top
// Record table with linear search, delete with shift, and selection sort.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue a transaction. Results appear for one
// cycle each, marked by done, and cannot be stalled; sort and dump give one
// result per record with last on the final one. Find, replace and delete scan
// the entries in order, delete then shifts each later entry down, and sort
// runs a selection pass per position over the table memory, followed by a
// read-out of every record.
module record_table_search_sort_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] key_id,
  input  logic signed [31:0] new_id,
  input  logic [1:0]         new_role,
  input  logic               descending,
  output logic               done,
  output logic [2:0]         status,
  output logic [5:0]         found_index,
  output logic signed [31:0] rec_id,
  output logic [1:0]         rec_role,
  output logic [6:0]         entry_total,
  output logic               last
);

  rtss_pkg::cmd_t  cmd;
  rtss_pkg::stat_t st;

  rtss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cmd(cmd)
  );

  rtss_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .func(func), .key_id(key_id), .new_id(new_id), .new_role(new_role),
    .descending(descending), .done(done), .status(status),
    .found_index(found_index), .rec_id(rec_id), .rec_role(rec_role),
    .entry_total(entry_total), .last(last)
  );

endmodule

// File: hw/rtl/rtss_ctrl.sv
// ----------------------------------------------------------------------------
// rtss_ctrl
// Sequencer for the record table: search, shift, selection sort, read-out.
// ----------------------------------------------------------------------------
module rtss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rtss_pkg::stat_t  st,
  output rtss_pkg::cmd_t   cmd
);

  rtss_pkg::state_t state, state_next;

  // advance state
  always_ff @(posedge clk) begin
    if (rst) state <= rtss_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != rtss_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rtss_pkg::S_IDLE: if (start) state_next = rtss_pkg::S_DISPATCH;
      rtss_pkg::S_DISPATCH: begin
        state_next = rtss_pkg::S_IDLE;
        if (st.func == rtss_pkg::FN_APPEND || st.func > rtss_pkg::FN_DUMP || st.empty)
          state_next = rtss_pkg::S_IDLE;
        else if (st.func == rtss_pkg::FN_DUMP) state_next = rtss_pkg::S_DUMP_RD;
        else if (st.func == rtss_pkg::FN_SORT) state_next = rtss_pkg::S_SORT_OUTER;
        else state_next = rtss_pkg::S_SRCH_RD;
      end
      rtss_pkg::S_SRCH_RD: state_next = rtss_pkg::S_SRCH_CMP;
      rtss_pkg::S_SRCH_CMP: begin
        if (st.match) begin
          if (st.func == rtss_pkg::FN_DELETE && !st.i_end) state_next = rtss_pkg::S_SHIFT_RD;
          else state_next = rtss_pkg::S_IDLE;
        end else if (st.i_end) state_next = rtss_pkg::S_IDLE;
        else state_next = rtss_pkg::S_SRCH_RD;
      end
      rtss_pkg::S_SHIFT_RD: state_next = rtss_pkg::S_SHIFT_WR;
      rtss_pkg::S_SHIFT_WR:
        state_next = st.i_end ? rtss_pkg::S_IDLE : rtss_pkg::S_SHIFT_RD;
      rtss_pkg::S_SORT_OUTER:
        state_next = st.i_end ? rtss_pkg::S_DUMP_RD : rtss_pkg::S_SORT_RD;
      rtss_pkg::S_SORT_RD: state_next = rtss_pkg::S_SORT_CMP;
      rtss_pkg::S_SORT_CMP: begin
        if (st.j_end) state_next = rtss_pkg::S_SWAP_A;
        else state_next = rtss_pkg::S_SORT_RD;
      end
      rtss_pkg::S_SWAP_A:
        state_next = st.best_is_i ? rtss_pkg::S_SORT_OUTER : rtss_pkg::S_SWAP_B;
      rtss_pkg::S_SWAP_B: state_next = rtss_pkg::S_SORT_OUTER;
      rtss_pkg::S_DUMP_RD: state_next = rtss_pkg::S_DUMP_OUT;
      rtss_pkg::S_DUMP_OUT:
        state_next = st.i_last_out ? rtss_pkg::S_IDLE : rtss_pkg::S_DUMP_RD;
      default: state_next = rtss_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state)
      rtss_pkg::S_IDLE: begin
        cmd.latch_in = start;
      end
      rtss_pkg::S_DISPATCH: begin
        cmd.i_clr = 1'b1;
        if (st.func == rtss_pkg::FN_APPEND) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          if (!st.role_ok) cmd.emit_status = rtss_pkg::ST_BAD_ROLE;
          else if (st.full) cmd.emit_status = rtss_pkg::ST_FULL;
          else begin
            cmd.wr_new = 1'b1;
            cmd.wr_sel = rtss_pkg::WR_COUNT;
            cmd.cnt_inc = 1'b1;
            cmd.emit_kind = rtss_pkg::EK_NEW;
            cmd.emit_status = rtss_pkg::ST_OK;
          end
        end else if (st.func <= rtss_pkg::FN_DUMP && st.empty) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_status = rtss_pkg::ST_EMPTY;
        end
      end
      rtss_pkg::S_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = rtss_pkg::RD_I;
      end
      rtss_pkg::S_SRCH_CMP: begin
        if (st.match) begin
          if (st.func == rtss_pkg::FN_DELETE) begin
            cmd.cnt_dec = 1'b1;
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = rtss_pkg::EK_HIT;
            cmd.emit_status = rtss_pkg::ST_OK;
          end else if (st.func == rtss_pkg::FN_REPLACE) begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            if (!st.role_ok) cmd.emit_status = rtss_pkg::ST_BAD_ROLE;
            else begin
              cmd.wr_new = 1'b1;
              cmd.wr_sel = rtss_pkg::WR_HIT;
              cmd.emit_kind = rtss_pkg::EK_NEW;
              cmd.emit_status = rtss_pkg::ST_OK;
            end
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = rtss_pkg::EK_HIT;
            cmd.emit_status = rtss_pkg::ST_OK;
          end
        end else if (st.i_end) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_status = rtss_pkg::ST_NOT_FOUND;
        end else begin
          cmd.i_inc = 1'b1;
        end
      end
      rtss_pkg::S_SHIFT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = rtss_pkg::RD_I1;
      end
      rtss_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.i_inc = 1'b1;
      end
      rtss_pkg::S_SORT_OUTER: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = rtss_pkg::RD_I;
        cmd.j_init = ~st.i_end;
        if (st.i_end) cmd.i_clr = 1'b1;
      end
      rtss_pkg::S_SORT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = rtss_pkg::RD_J;
      end
      rtss_pkg::S_SORT_CMP: begin
        cmd.best_upd = 1'b1;
        cmd.j_inc = 1'b1;
        if (st.j_end) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = rtss_pkg::RD_I;
        end
      end
      rtss_pkg::S_SWAP_A: begin
        cmd.save_i = 1'b1;
        if (!st.best_is_i) cmd.swap_a = 1'b1;
        else cmd.i_inc = 1'b1;
      end
      rtss_pkg::S_SWAP_B: begin
        cmd.swap_b = 1'b1;
        cmd.i_inc = 1'b1;
      end
      rtss_pkg::S_DUMP_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = rtss_pkg::RD_I;
      end
      rtss_pkg::S_DUMP_OUT: begin
        cmd.emit = 1'b1;
        cmd.emit_kind = rtss_pkg::EK_RD;
        cmd.emit_status = rtss_pkg::ST_OK;
        cmd.emit_last = st.i_last_out;
        cmd.i_inc = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/rtss_dp.sv
// ----------------------------------------------------------------------------
// rtss_dp
// Record memory, index counters, compare logic and result register.
// ----------------------------------------------------------------------------
module rtss_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rtss_pkg::cmd_t             cmd,
  output rtss_pkg::stat_t            st,
  input  logic [2:0]                 func,
  input  logic signed [31:0]         key_id,
  input  logic signed [31:0]         new_id,
  input  logic [1:0]                 new_role,
  input  logic                       descending,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [5:0]                 found_index,
  output logic signed [31:0]         rec_id,
  output logic [1:0]                 rec_role,
  output logic [6:0]                 entry_total,
  output logic                       last
);

  localparam int IW = rtss_pkg::IdxW;
  localparam int CW = rtss_pkg::CntW;

  logic [33:0] mem [rtss_pkg::TableDepth];

  logic [2:0]        f_func;
  logic [31:0]       f_key, f_nid;
  logic [1:0]        f_role;
  logic              f_desc;
  logic [CW-1:0]     count;
  logic [CW-1:0]     i, j;
  logic [IW-1:0]     best;
  logic [33:0]       rd_data, best_data, save_data;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [33:0]       wr_data;
  logic              wr_en;
  logic [CW-1:0]     i_plus1;
  logic [31:0]       a_id, b_id;
  logic              best_load;

  assign i_plus1 = i + 1'b1;

  // capture transaction fields
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      f_func <= func;
      f_key  <= key_id;
      f_nid  <= new_id;
      f_role <= new_role;
      f_desc <= descending;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      rtss_pkg::RD_I:    rd_addr = i[IW-1:0];
      rtss_pkg::RD_I1:   rd_addr = i_plus1[IW-1:0];
      rtss_pkg::RD_J:    rd_addr = j[IW-1:0];
      rtss_pkg::RD_BEST: rd_addr = best;
      default:           rd_addr = i[IW-1:0];
    endcase
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i[IW-1:0];
    wr_data = rd_data;
    if (cmd.wr_new) begin
      wr_en   = 1'b1;
      wr_addr = (cmd.wr_sel == rtss_pkg::WR_HIT) ? i[IW-1:0] : count[IW-1:0];
      wr_data = {f_nid, f_role};
    end else if (cmd.wr_shift) begin
      wr_en = 1'b1;
    end else if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_data = best_data;
    end else if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = best;
      wr_data = save_data;
    end
  end

  // record memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  // count and indices
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
    if (cmd.i_clr) i <= '0;
    else if (cmd.i_inc) i <= i_plus1;
    if (cmd.j_init) j <= i_plus1;
    else if (cmd.j_inc) j <= j + 1'b1;
  end

  // best tracking for the selection pass
  always_ff @(posedge clk) begin
    if (cmd.j_init) best <= i[IW-1:0];
    else if (cmd.best_upd && st.better) best <= j[IW-1:0];
    if (cmd.save_i) save_data <= rd_data;
  end

  // the best entry is loaded from the read issued in the outer step
  always_ff @(posedge clk) begin
    if (rst) best_load <= 1'b0;
    else     best_load <= cmd.j_init;
  end
  always_ff @(posedge clk) begin
    if (best_load) best_data <= rd_data;
    else if (cmd.best_upd && st.better) best_data <= rd_data;
  end

  // status
  assign a_id = rd_data[33:2] ^ 32'h8000_0000;
  assign b_id = best_data[33:2] ^ 32'h8000_0000;
  always_comb begin
    st.func       = f_func;
    st.role_ok    = (f_role != 2'd0);
    st.full       = (count >= CW'(rtss_pkg::TableDepth));
    st.empty      = (count == '0);
    st.match      = (rd_data[33:2] == f_key);
    st.better     = f_desc ? (a_id > b_id) : (a_id < b_id);
    st.i_end      = (i_plus1 >= count);
    st.i_last_out = (i_plus1 == count);
    st.j_end      = (j + 1'b1 >= count);
    st.best_is_i  = (best == i[IW-1:0]);
  end

  // result register, counts taken after the update
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
    if (cmd.emit) begin
      status <= cmd.emit_status;
      last   <= cmd.emit_last;
      entry_total <= 7'(count + (cmd.cnt_inc ? 1'b1 : 1'b0) - (cmd.cnt_dec ? 1'b1 : 1'b0));
      case (cmd.emit_kind)
        rtss_pkg::EK_NEW: begin
          found_index <= 6'(cmd.wr_sel == rtss_pkg::WR_HIT ? i : count);
          rec_id      <= f_nid;
          rec_role    <= f_role;
        end
        rtss_pkg::EK_HIT: begin
          found_index <= 6'(i);
          rec_id      <= rd_data[33:2];
          rec_role    <= rd_data[1:0];
        end
        rtss_pkg::EK_RD: begin
          found_index <= 6'(i);
          rec_id      <= rd_data[33:2];
          rec_role    <= rd_data[1:0];
        end
        default: begin
          found_index <= '0;
          rec_id      <= '0;
          rec_role    <= '0;
        end
      endcase
    end
  end

endmodule
